>>> sv/assert_macros.svh
// Assertion macros shared by the longest-chain tracker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside of reset.
`define FMLS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("fmls assertion failed");
// Check a property on every clock edge, reset included.
`define FMLS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("fmls assertion failed");
`else
`define FMLS_ASSERT(lbl, prop)
`define FMLS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> sv/fmls_pkg.sv
// Shared constants, types and control structs of the longest-chain tracker.
`default_nettype none
package fmls_pkg;

  localparam int VALUE_BITS  = 16;
  localparam int LENGTH_BITS = 24;
  localparam int TREE_DEPTH  = 1 << VALUE_BITS;

  typedef logic [VALUE_BITS-1:0]  value_t;
  typedef logic [VALUE_BITS:0]    index_t;
  typedef logic [LENGTH_BITS-1:0] length_t;

  localparam length_t LEN_MAX = '1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic q_step;
    logic chain;
    logic u_rd;
    logic u_wr;
    logic out_load;
    logic clr;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic idx_zero;
    logic upd_done;
    logic clr_done;
    logic out_free;
    logic last;
  } dp_status_t;

endpackage
`default_nettype wire

>>> sv/fmls_dpath.sv
// Datapath: tree memory, index walker, maxima, output word and mode register.
`default_nettype none
`include "assert_macros.svh"
module fmls_dpath
  import fmls_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire dp_cmd_t    cmd,
  output dp_status_t      status,
  input  wire value_t     in_value,
  input  wire logic       in_last,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_data,
  input  wire logic       out_stall,
  output logic            out_valid,
  output length_t         out_chain_length,
  output length_t         out_best_length,
  output logic            out_last_out
);

  length_t mem [TREE_DEPTH];

  length_t rd_r;
  index_t  idx_r;
  length_t qmax_r;
  length_t chain_r;
  length_t best_r;
  value_t  val_r;
  value_t  clr_cnt_r;
  logic    last_r;
  logic    pend_r;
  logic    strict_r;
  logic    out_valid_r;
  length_t out_chain_r;
  length_t out_best_r;
  logic    out_last_r;

  index_t  idx_start;
  index_t  idx_neg;
  index_t  idx_low;
  length_t chain_w;
  value_t  mem_addr;
  logic    mem_we;
  logic    mem_re;
  length_t mem_wdata;

  // start of the prefix walk: below the value in strict mode, at it otherwise
  always_comb begin
    if (strict_r) begin
      idx_start = (in_value == '0) ? '0 : ({1'b0, in_value} - index_t'(1));
    end else begin
      idx_start = {1'b0, in_value};
    end
  end

  assign idx_neg = index_t'(~idx_r) + index_t'(1);
  assign idx_low = idx_r & idx_neg;

  // saturating increment of the query maximum
  assign chain_w = (qmax_r == LEN_MAX) ? LEN_MAX : (qmax_r + length_t'(1));

  // single memory port: clear sweep or tree walk
  assign mem_addr  = cmd.clr ? clr_cnt_r : idx_r[VALUE_BITS-1:0];
  assign mem_we    = cmd.clr || (cmd.u_wr && (rd_r < chain_r));
  assign mem_re    = cmd.q_step || cmd.u_rd;
  assign mem_wdata = cmd.clr ? '0 : chain_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= mem[mem_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
      best_r      <= '0;
    end else begin
      if (cfg_valid) begin
        strict_r <= cfg_data;
      end
      pend_r <= cmd.q_step;
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + value_t'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.chain && (chain_w > best_r)) begin
        best_r <= chain_w;
      end else if (cmd.out_load && last_r) begin
        best_r <= '0;
      end
    end
  end

  // walker and payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r  <= in_value;
      last_r <= in_last;
      idx_r  <= idx_start;
      qmax_r <= '0;
    end else if (cmd.q_step) begin
      idx_r <= idx_r & (idx_r - index_t'(1));
    end else if (cmd.chain) begin
      idx_r <= {1'b0, val_r};
    end else if (cmd.u_wr) begin
      idx_r <= idx_r + idx_low;
    end
    // fold in the word read by the previous query step
    if (pend_r && (rd_r > qmax_r)) begin
      qmax_r <= rd_r;
    end
    if (cmd.chain) begin
      chain_r <= chain_w;
    end
    if (cmd.out_load) begin
      out_chain_r <= chain_r;
      out_best_r  <= best_r;
      out_last_r  <= last_r;
    end
  end

  assign status.idx_zero = (idx_r == '0);
  assign status.upd_done = (idx_r == '0) || idx_r[VALUE_BITS];
  assign status.clr_done = &clr_cnt_r;
  assign status.out_free = !out_valid_r || !out_stall;
  assign status.last     = last_r;

  assign out_valid        = out_valid_r;
  assign out_chain_length = out_chain_r;
  assign out_best_length  = out_best_r;
  assign out_last_out     = out_last_r;

  `FMLS_ASSERT(a_qmax_grows, pend_r |=> (qmax_r >= $past(qmax_r)))
  `FMLS_ASSERT(a_best_covers_chain, cmd.chain |=> (best_r >= chain_r))
  `FMLS_ASSERT(a_best_cleared, (cmd.out_load && last_r) |=> (best_r == '0))

endmodule
`default_nettype wire

>>> sv/fmls_ctrl.sv
// Controller: sequences clear sweep, prefix query, tree update and output.
`default_nettype none
`include "assert_macros.svh"
module fmls_ctrl
  import fmls_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_CHAIN,
    ST_URD,
    ST_UWR,
    ST_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // decode commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_QUERY;
        end
      end
      ST_QUERY: begin
        if (status.idx_zero) begin
          state_nxt = ST_CHAIN;
        end else begin
          cmd.q_step = 1'b1;
        end
      end
      ST_CHAIN: begin
        cmd.chain = 1'b1;
        state_nxt = ST_URD;
      end
      ST_URD: begin
        if (status.upd_done) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.u_rd  = 1'b1;
          state_nxt = ST_UWR;
        end
      end
      ST_UWR: begin
        cmd.u_wr  = 1'b1;
        state_nxt = ST_URD;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = status.last ? ST_CLEAR : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // hold state; sweep the tree after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  `FMLS_ASSERT(a_write_after_read, (state_r == ST_UWR) |-> ($past(state_r) == ST_URD))
  `FMLS_ASSERT(a_query_drained, (state_r == ST_CHAIN) |-> status.idx_zero)

endmodule
`default_nettype wire

>>> sv/fenwick_max_longest_subsequence_core.sv
// Top level of the longest-chain tracker: controller, datapath and ports.
`default_nettype none
// Streams 16-bit values and reports, per word, the longest chain ending at
// that value and the best chain so far, using a prefix-maximum Fenwick tree
// of 65536 x 24-bit entries in one single-port memory. One word is in flight
// at a time: a word is accepted, then the query reads one entry per set bit
// of the query index, the chain length is formed, the update walk reads each
// tree level and raises it where smaller, and the output register is loaded.
// Query bits and update levels trade off against each other (value 1 in
// non-decreasing mode: one query read, sixteen update levels); the memory
// port is shared by query and read-modify-write, and a result still held by
// out_stall keeps the controller waiting to load the next result. After reset
// and after each word marked last the tree is swept to zero one entry per
// cycle, with in_stall high; strict_mode writes are taken at any time
// (cfg_ready stays high). Zero values give a chain length of one and leave
// the tree untouched; lengths saturate at all ones.
module fenwick_max_longest_subsequence_core
  import fmls_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire value_t  in_value,
  input  wire logic    in_last,
  output logic         out_valid,
  input  wire logic    out_stall,
  output length_t      out_chain_length,
  output length_t      out_best_length,
  output logic         out_last_out,
  input  wire logic    cfg_valid,
  output logic         cfg_ready,
  input  wire logic    cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // mode register is always writable
  assign cfg_ready = 1'b1;

  fmls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  fmls_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_value         (in_value),
    .in_last          (in_last),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_chain_length (out_chain_length),
    .out_best_length  (out_best_length),
    .out_last_out     (out_last_out)
  );

endmodule
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the Fenwick-tree longest-chain tracker core.
`default_nettype none
module testbench
  import fmls_pkg::*;
();

  // one expected result word
  typedef struct packed {
    length_t chain;
    length_t best;
    logic    last;
  } chain_result_t;

  // Track prefix maxima of chain lengths and compare result words against them.
  class chain_scoreboard;
    length_t       prefix_max_tree [int unsigned];
    length_t       best_len;
    logic          strict;
    chain_result_t expected_results [$];
    int            errors;

    function new();
      best_len = '0;
      strict   = 1'b0;
      errors   = 0;
    endfunction

    function void set_mode(logic m);
      strict = m;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // entries never written read as zero
    function length_t node(int unsigned idx);
      return prefix_max_tree.exists(idx) ? prefix_max_tree[idx] : '0;
    endfunction

    // Predict the result of one accepted input word and advance the tree.
    function void note_word(value_t v, logic l);
      int unsigned   idx;
      length_t       top;
      length_t       chain;
      chain_result_t res;
      top = '0;
      idx = v;
      // strict mode looks only at smaller values; zero covers nothing
      if (strict && idx != 0) idx = idx - 1;
      while (idx != 0) begin
        if (node(idx) > top) top = node(idx);
        idx = idx & (idx - 1);
      end
      chain = (top == LEN_MAX) ? LEN_MAX : top + 1'b1;
      if (chain > best_len) best_len = chain;
      // raise the covering entries; zero leaves the tree alone
      idx = v;
      if (idx != 0) begin
        while (idx < TREE_DEPTH) begin
          if (node(idx) < chain) prefix_max_tree[idx] = chain;
          idx = idx + (idx & (~idx + 1));
        end
      end
      res.chain = chain;
      res.best  = best_len;
      res.last  = l;
      expected_results.push_back(res);
      // a last word ends the sequence
      if (l) begin
        prefix_max_tree.delete();
        best_len = '0;
      end
    endfunction

    // Compare one accepted result word with the oldest prediction.
    function void check_word(length_t chain, length_t best, logic l);
      chain_result_t res;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word: chain %0d best %0d last %0b",
                 $time, chain, best, l);
        errors++;
        return;
      end
      res = expected_results.pop_front();
      if (res.chain !== chain) begin
        $display("%0t: chain_length expected %0d actual %0d", $time, res.chain, chain);
        errors++;
      end
      if (res.best !== best) begin
        $display("%0t: best_length expected %0d actual %0d", $time, res.best, best);
        errors++;
      end
      if (res.last !== l) begin
        $display("%0t: last_out expected %0b actual %0b", $time, res.last, l);
        errors++;
      end
    endfunction
  endclass

  localparam int SETTLE_CYCLES = 64;
  localparam int IDLE_LIMIT    = 250000;
  localparam int RANDOM_RUNS   = 7;

  typedef enum int {PAT_SMALL, PAT_RISE, PAT_FALL, PAT_WIDE, PAT_EDGE} word_pattern_t;

  logic    clk;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_stall;
  value_t  in_value  = '0;
  logic    in_last   = 1'b0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  length_t out_chain_length;
  length_t out_best_length;
  logic    out_last_out;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic    cfg_data  = 1'b0;

  bit quiet = 1'b0;
  int stall_left = 0;
  int calm_left  = 0;

  chain_scoreboard chain_sb = new();

  // duplicates, extremes and a zero value for the non-decreasing run
  value_t nondec_words [13] = '{16'd1, 16'd65535, 16'd1, 16'd1, 16'd2, 16'd32768, 16'd0,
                                16'd65535, 16'd65535, 16'h5555, 16'hAAAA, 16'd3, 16'd4};
  // repeated values separate strict from non-strict counting
  value_t strict_words [12] = '{16'd1, 16'd1, 16'd2, 16'd2, 16'd0, 16'd0, 16'd65535,
                                16'd65535, 16'd16, 16'd8, 16'd32767, 16'd65534};

  fenwick_max_longest_subsequence_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chain_length (out_chain_length),
    .out_best_length  (out_best_length),
    .out_last_out     (out_last_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the result side in bursts, separated by calm stretches.
  always @(posedge clk) begin
    if (stall_left == 0 && calm_left == 0) begin
      if ($urandom_range(0, 1)) stall_left = $urandom_range(1, 18);
      else calm_left = $urandom_range(1, 150);
    end
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      calm_left--;
    end
  end

  // Sample handshakes mid-cycle, where all signals are settled.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) chain_sb.note_word(in_value, in_last);
      if (out_valid && !out_stall)
        chain_sb.check_word(out_chain_length, out_best_length, out_last_out);
      if (cfg_valid && cfg_ready) chain_sb.set_mode(cfg_data);
    end
  end

  // End the run when no word moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Offer one input word and hold it until taken.
  task automatic send_word(input value_t v, input logic l);
    logic taken;
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= l;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
  endtask

  // Write strict_mode and hold the write until taken.
  task automatic write_mode(input logic m);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Drain outstanding results, let the block settle, then set the mode.
  task automatic begin_phase(input logic m);
    while (chain_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_mode(m);
  endtask

  // Send one random sequence built from bursts of patterns, ending in last.
  task automatic run_sequence(input int count);
    word_pattern_t pattern;
    int burst;
    int gap_odds;
    int span;
    int step;
    int cur;
    int sent;
    int k;
    sent = 0;
    cur  = 1;
    while (sent < count) begin
      pattern = word_pattern_t'($urandom_range(0, 4));
      burst   = $urandom_range(1, 30);
      span    = $urandom_range(2, 64);
      step    = $urandom_range(0, 3);
      case ($urandom_range(0, 3))
        0:       gap_odds = 0;
        1:       gap_odds = 10;
        2:       gap_odds = 30;
        default: gap_odds = 60;
      endcase
      if (pattern == PAT_RISE || pattern == PAT_FALL) cur = $urandom_range(1, 65535);
      for (int n = 0; n < burst && sent < count; n++) begin
        case (pattern)
          PAT_SMALL: cur = $urandom_range(1, span);
          PAT_RISE:  cur = (cur + step > 65535) ? 1 : cur + step;
          PAT_FALL:  cur = (cur - step < 1) ? 65535 : cur - step;
          PAT_WIDE:  cur = $urandom_range(1, 65535);
          default: begin
            // powers of two and their neighbors hit tree boundaries
            k = $urandom_range(0, 15);
            case ($urandom_range(0, 3))
              0:       cur = 1 << k;
              1:       cur = (1 << k) - 1;
              2:       cur = (1 << k) + 1;
              default: cur = 65535;
            endcase
            if (cur == 0) cur = 1;
          end
        endcase
        if (!quiet && gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        sent++;
        send_word(value_t'(cur), sent == count);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed non-decreasing run
    begin_phase(1'b0);
    foreach (nondec_words[i]) send_word(nondec_words[i], i == $size(nondec_words) - 1);
    in_valid <= 1'b0;

    // directed strictly increasing run
    begin_phase(1'b1);
    foreach (strict_words[i]) send_word(strict_words[i], i == $size(strict_words) - 1);
    in_valid <= 1'b0;

    // random sequences, alternating mode; the final one runs without idling
    for (int p = 0; p < RANDOM_RUNS; p++) begin
      begin_phase(p % 2 == 1);
      if (p == RANDOM_RUNS - 1) quiet = 1'b1;
      run_sequence($urandom_range(180, 240));
    end

    while (chain_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (chain_sb.errors == 0 && chain_sb.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+sv
sv/fmls_pkg.sv
sv/fmls_dpath.sv
sv/fmls_ctrl.sv
sv/fenwick_max_longest_subsequence_core.sv
test/testbench.sv
